// ----- rtl/core/sph_ghost_particle_generator_unit_assert.svh -----
// Assertion macros used by the ghost generator checker.
`ifndef SPH_GHOST_PARTICLE_GENERATOR_UNIT_ASSERT_SVH
`define SPH_GHOST_PARTICLE_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SGG_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ghost generator check failed");

// Next-cycle implication, disabled during reset.
`define SGG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ghost generator check failed");

`endif

// ----- rtl/core/sgg_pkg.sv -----
// Types, codes and helpers shared by the ghost particle generator.
package sgg_pkg;

  localparam int COORD_W = 32;
  localparam int IDX_W   = 16;
  localparam int CNT_W   = 17;
  localparam int RF_W    = 16;
  localparam int REACH_W = 40;  // 16 x 32 product with 8 fraction bits dropped
  localparam int THR_W   = 42;  // 32-bit bound plus 40-bit reach, signed
  localparam int SIZE_W  = 33;
  localparam int SUM_W   = 35;
  localparam int MODES_W = 12;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODES    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REACH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 3'd5;

  localparam logic [RF_W-1:0]  REACH_RESET    = 16'd563;
  localparam logic [CNT_W-1:0] CAPACITY_RESET = 17'd65536;

  // Face modes
  localparam logic [1:0] MODE_OPEN     = 2'd0;
  localparam logic [1:0] MODE_PERIODIC = 2'd1;
  localparam logic [1:0] MODE_MIRROR   = 2'd2;
  localparam logic [1:0] MODE_NONE     = 2'd3;

  localparam logic KIND_PARTICLE   = 1'b0;
  localparam logic KIND_BEGIN_STEP = 1'b1;

  localparam logic signed [SUM_W-1:0] SAT_MAX = 35'sd2147483647;
  localparam logic signed [SUM_W-1:0] SAT_MIN = -35'sd2147483648;

  typedef struct packed {
    logic                      kind;
    logic [IDX_W-1:0]          particle_index;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] vel_x;
    logic signed [COORD_W-1:0] vel_y;
    logic signed [COORD_W-1:0] vel_z;
    logic [COORD_W-1:0]        smoothing_length;
  } particle_t;

  typedef struct packed {
    logic [IDX_W-1:0]          source_index;
    logic [IDX_W-1:0]          ghost_number;
    logic signed [COORD_W-1:0] ghost_x;
    logic signed [COORD_W-1:0] ghost_y;
    logic signed [COORD_W-1:0] ghost_z;
    logic signed [COORD_W-1:0] ghost_vx;
    logic signed [COORD_W-1:0] ghost_vy;
    logic signed [COORD_W-1:0] ghost_vz;
    logic                      last_of_particle;
    logic                      overflow;
  } ghost_t;

  // One stored ghost: slot number, position and velocity, x in element 0
  typedef struct packed {
    logic [IDX_W-1:0]            number;
    logic [2:0][COORD_W-1:0]     pos;
    logic [2:0][COORD_W-1:0]     vel;
  } entry_t;

  // Face test request from the sequencer
  typedef struct packed {
    logic [1:0]                mode;
    logic                      low_side;
    logic signed [COORD_W-1:0] coord;
    logic signed [COORD_W-1:0] vel;
    logic signed [THR_W-1:0]   lo_thr;
    logic signed [THR_W-1:0]   hi_thr;
    logic signed [SIZE_W-1:0]  size;
    logic signed [COORD_W-1:0] bface;
  } side_req_t;

  typedef struct packed {
    logic                      near;
    logic signed [COORD_W-1:0] pos;
    logic signed [COORD_W-1:0] vel;
  } side_res_t;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[COORD_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/sgg_stream_if.sv -----
// Valid/ready stream interface carrying one typed payload per transaction.
interface sgg_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/sgg_side_unit.sv -----
// Shared face unit: near test and shifted or reflected coordinate for one face.
module sgg_side_unit import sgg_pkg::*; (
  input  side_req_t req,
  output side_res_t res
);

  logic                    periodic;
  logic                    mirror;
  logic signed [THR_W-1:0] coord_w;
  logic                    near_lo;
  logic                    near_hi;
  logic signed [SUM_W-1:0] coord_s;
  logic signed [SUM_W-1:0] size_s;
  logic signed [SUM_W-1:0] bface2;
  logic signed [SUM_W-1:0] vel_s;
  logic signed [SUM_W-1:0] op_a;
  logic signed [SUM_W-1:0] op_b;
  logic signed [SUM_W-1:0] sum;

  assign periodic = (req.mode == MODE_PERIODIC);
  assign mirror   = (req.mode == MODE_MIRROR);

  // Near test against precomputed thresholds
  assign coord_w = $signed({{(THR_W-COORD_W){req.coord[COORD_W-1]}}, req.coord});
  assign near_lo = coord_w < req.lo_thr;
  assign near_hi = coord_w > req.hi_thr;
  assign res.near = (periodic || mirror) && (req.low_side ? near_lo : near_hi);

  // Periodic: coord +/- size. Mirror: 2*face - coord.
  assign coord_s = $signed({{(SUM_W-COORD_W){req.coord[COORD_W-1]}}, req.coord});
  assign size_s  = $signed({{(SUM_W-SIZE_W){req.size[SIZE_W-1]}}, req.size});
  assign bface2  = $signed({{(SUM_W-COORD_W-1){req.bface[COORD_W-1]}}, req.bface, 1'b0});
  assign vel_s   = $signed({{(SUM_W-COORD_W){req.vel[COORD_W-1]}}, req.vel});

  assign op_a = periodic ? coord_s : -coord_s;
  assign op_b = periodic ? (req.low_side ? size_s : -size_s) : bface2;
  assign sum  = op_a + op_b;

  assign res.pos = sat32(sum);
  assign res.vel = mirror ? sat32(-vel_s) : req.vel;

endmodule

// ----- rtl/core/sgg_ghost_store.sv -----
// Pending ghost store: one write port, one registered read port.
module sgg_ghost_store import sgg_pkg::*; #(
  parameter int DEPTH = 26
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  entry_t                   wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output entry_t                   rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/sph_ghost_particle_generator_unit.sv -----
// Top level of the SPH ghost particle generator: sequencer, registers, output stage.
//
// Usage:
//   particle (sink): one transaction per item. kind = begin step clears the
//     step's ghost counter and produces nothing. kind = particle produces
//     that particle's ghosts on the ghost channel, lowest slot first.
//   ghost (source): one transaction per kept ghost, last_of_particle on the
//     final one, overflow on all of them if any ghost was dropped. A particle
//     that kept none but dropped some gives one marker transaction.
//   cfg_we/cfg_index/cfg_data: register writes, only while the block is idle.
// Timing: one particle at a time; particle.ready is high only when idle.
//   Generation runs axis by axis; the candidates of an axis are the particle
//   plus the ghosts made so far, and every candidate goes through the single
//   face unit, one face per cycle. Each ghost is then read from the pending
//   store and presented (store read, output load, transaction).
// Reset: registers return to their reset values, the ghost counter clears.
// A stalled receiver holds the output register; generation does not restart.
module sph_ghost_particle_generator_unit import sgg_pkg::*; #(
  parameter int DIMS = 3,
  parameter int MAX_GHOSTS_PER_PARTICLE = 26
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  sgg_stream_if.sink            particle,
  sgg_stream_if.source          ghost
);

  localparam int KW = $clog2(MAX_GHOSTS_PER_PARTICLE + 1);
  localparam int AW = $clog2(MAX_GHOSTS_PER_PARTICLE);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_MUL       = 3'd1;
  localparam logic [2:0] ST_AXIS      = 3'd2;
  localparam logic [2:0] ST_CAND      = 3'd3;
  localparam logic [2:0] ST_SIDE      = 3'd4;
  localparam logic [2:0] ST_EMIT_RD   = 3'd5;
  localparam logic [2:0] ST_EMIT_LD   = 3'd6;
  localparam logic [2:0] ST_EMIT_WAIT = 3'd7;

  // Configuration registers
  logic [CFG_DATA_W-1:0] box_x;
  logic [CFG_DATA_W-1:0] box_y;
  logic [CFG_DATA_W-1:0] box_z;
  logic [MODES_W-1:0]    modes;
  logic [RF_W-1:0]       reach_factor;
  logic [CNT_W-1:0]      capacity;

  // Sequencer state
  logic [2:0]               state;
  logic [CNT_W-1:0]         ghost_count;
  particle_t                part;
  logic [REACH_W-1:0]       reach;
  logic [1:0]               axis;
  logic                     side;
  logic [KW-1:0]            cand_c;
  logic [KW-1:0]            n_axis;
  logic [KW-1:0]            kept;
  logic [KW-1:0]            emit_r;
  logic                     dropped;
  logic signed [THR_W-1:0]  lo_thr;
  logic signed [THR_W-1:0]  hi_thr;
  logic signed [SIZE_W-1:0] size;
  ghost_t                   out_r;
  logic                     out_valid;

  logic [RF_W+COORD_W-1:0]   product;
  logic [CFG_DATA_W-1:0]     box_cur;
  logic signed [COORD_W-1:0] bmin;
  logic signed [COORD_W-1:0] bmax;
  logic [KW-1:0]             cand_m1;
  logic [AW-1:0]             raddr;
  logic                      store_we;
  entry_t                    real_entry;
  entry_t                    q;
  entry_t                    cand;
  entry_t                    wentry;
  side_req_t                 req;
  side_res_t                 res;
  logic [3:0]                mode_idx;
  logic                      room;
  logic                      last_axis;
  logic                      last_emit;

  assign particle.ready = (state == ST_IDLE);
  assign ghost.valid    = out_valid;
  assign ghost.payload  = out_r;

  // Bounds of the axis in work
  always_comb begin
    case (axis)
      2'd0:    box_cur = box_x;
      2'd1:    box_cur = box_y;
      default: box_cur = box_z;
    endcase
  end
  assign bmin = $signed(box_cur[COORD_W-1:0]);
  assign bmax = $signed(box_cur[CFG_DATA_W-1:COORD_W]);

  assign product = reach_factor * part.smoothing_length;

  // Candidate: the particle itself or a ghost read back from the store
  assign real_entry.number = '0;
  assign real_entry.pos    = {part.pos_z, part.pos_y, part.pos_x};
  assign real_entry.vel    = {part.vel_z, part.vel_y, part.vel_x};
  assign cand_m1 = cand_c - KW'(1);
  assign raddr   = (state == ST_EMIT_RD) ? emit_r[AW-1:0] : cand_m1[AW-1:0];
  assign cand    = (cand_c == '0) ? real_entry : q;

  // Face request
  assign mode_idx     = {axis, side, 1'b0};
  assign req.mode     = modes[mode_idx +: 2];
  assign req.low_side = !side;
  assign req.coord    = $signed(cand.pos[axis]);
  assign req.vel      = $signed(cand.vel[axis]);
  assign req.lo_thr   = lo_thr;
  assign req.hi_thr   = hi_thr;
  assign req.size     = size;
  assign req.bface    = side ? bmax : bmin;

  sgg_side_unit u_side (
    .req (req),
    .res (res)
  );

  // New ghost from the candidate
  always_comb begin
    wentry           = cand;
    wentry.pos[axis] = res.pos;
    wentry.vel[axis] = res.vel;
    wentry.number    = ghost_count[IDX_W-1:0];
  end

  assign room      = (kept < KW'(MAX_GHOSTS_PER_PARTICLE)) && (ghost_count < capacity);
  assign store_we  = (state == ST_SIDE) && res.near && room;
  assign last_axis = (axis == 2'(DIMS - 1));
  assign last_emit = ((emit_r + KW'(1)) == kept);

  sgg_ghost_store #(
    .DEPTH (MAX_GHOSTS_PER_PARTICLE)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (kept[AW-1:0]),
    .wdata (wentry),
    .raddr (raddr),
    .rdata (q)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      box_x        <= '0;
      box_y        <= '0;
      box_z        <= '0;
      modes        <= '0;
      reach_factor <= REACH_RESET;
      capacity     <= CAPACITY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BOX_X:    box_x        <= cfg_data;
        REG_BOX_Y:    box_y        <= cfg_data;
        REG_BOX_Z:    box_z        <= cfg_data;
        REG_MODES:    modes        <= cfg_data[MODES_W-1:0];
        REG_REACH:    reach_factor <= cfg_data[RF_W-1:0];
        REG_CAPACITY: capacity     <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      ghost_count <= '0;
      out_valid   <= 1'b0;
      axis        <= '0;
      side        <= 1'b0;
      cand_c      <= '0;
      n_axis      <= '0;
      kept        <= '0;
      emit_r      <= '0;
      dropped     <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (particle.valid) begin
            if (particle.payload.kind == KIND_BEGIN_STEP) begin
              ghost_count <= '0;
            end else begin
              kept    <= '0;
              dropped <= 1'b0;
              axis    <= '0;
              state   <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          state <= ST_AXIS;
        end
        ST_AXIS: begin
          cand_c <= '0;
          n_axis <= kept;
          state  <= ST_CAND;
        end
        ST_CAND: begin
          side  <= 1'b0;
          state <= ST_SIDE;
        end
        ST_SIDE: begin
          if (res.near) begin
            if (room) begin
              kept        <= kept + KW'(1);
              ghost_count <= ghost_count + CNT_W'(1);
            end else begin
              dropped <= 1'b1;
            end
          end
          if (!side) begin
            side <= 1'b1;
          end else if (cand_c != n_axis) begin
            cand_c <= cand_c + KW'(1);
            state  <= ST_CAND;
          end else if (last_axis) begin
            emit_r <= '0;
            state  <= ST_EMIT_RD;
          end else begin
            axis  <= axis + 2'd1;
            state <= ST_AXIS;
          end
        end
        ST_EMIT_RD: begin
          if (kept != '0) begin
            state <= ST_EMIT_LD;
          end else if (dropped) begin
            out_valid <= 1'b1;
            state     <= ST_EMIT_WAIT;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_EMIT_LD: begin
          out_valid <= 1'b1;
          state     <= ST_EMIT_WAIT;
        end
        ST_EMIT_WAIT: begin
          if (ghost.ready) begin
            out_valid <= 1'b0;
            if (out_r.last_of_particle) begin
              state <= ST_IDLE;
            end else begin
              emit_r <= emit_r + KW'(1);
              state  <= ST_EMIT_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      part <= particle.payload;
    end
    if (state == ST_MUL) begin
      reach <= product[RF_W+COORD_W-1:8];
    end
    if (state == ST_AXIS) begin
      lo_thr <= THR_W'(bmin) + $signed({2'b00, reach});
      hi_thr <= THR_W'(bmax) - $signed({2'b00, reach});
      size   <= SIZE_W'(bmax) - SIZE_W'(bmin);
    end
    if (state == ST_EMIT_RD) begin
      // marker for a particle that kept nothing
      out_r.source_index     <= part.particle_index;
      out_r.ghost_number     <= ghost_count[IDX_W-1:0];
      out_r.ghost_x          <= '0;
      out_r.ghost_y          <= '0;
      out_r.ghost_z          <= '0;
      out_r.ghost_vx         <= '0;
      out_r.ghost_vy         <= '0;
      out_r.ghost_vz         <= '0;
      out_r.last_of_particle <= 1'b1;
      out_r.overflow         <= 1'b1;
    end
    if (state == ST_EMIT_LD) begin
      out_r.source_index     <= part.particle_index;
      out_r.ghost_number     <= q.number;
      out_r.ghost_x          <= $signed(q.pos[0]);
      out_r.ghost_y          <= $signed(q.pos[1]);
      out_r.ghost_z          <= $signed(q.pos[2]);
      out_r.ghost_vx         <= $signed(q.vel[0]);
      out_r.ghost_vy         <= $signed(q.vel[1]);
      out_r.ghost_vz         <= $signed(q.vel[2]);
      out_r.last_of_particle <= last_emit;
      out_r.overflow         <= dropped;
    end
  end

endmodule

// ----- rtl/core/sgg_checker.sv -----
// Port-level checks for the ghost generator and their bind to the top level.
`include "sph_ghost_particle_generator_unit_assert.svh"

module sgg_checker import sgg_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input ghost_t out_data
);

  // a held ghost transaction keeps its contents
  `SGG_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))

  // no new particle is taken while ghosts are still being shown
  `SGG_ASSERT_IMP(a_one_particle, clk, rst, in_ready, !out_valid)

  // the last ghost frees the input side straight away
  `SGG_ASSERT_NEXT(a_last_frees, clk, rst, out_valid && out_ready && out_data.last_of_particle, in_ready)

  // further ghosts of the same particle keep the input closed
  `SGG_ASSERT_NEXT(a_more_follow, clk, rst, out_valid && out_ready && !out_data.last_of_particle, !in_ready)

endmodule

bind sph_ghost_particle_generator_unit sgg_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (particle.ready),
  .out_valid (ghost.valid),
  .out_ready (ghost.ready),
  .out_data  (ghost.payload)
);

// ----- verif/tb_top.sv -----
// Self-checking testbench for the SPH ghost particle generator unit.
`timescale 1ns / 100ps

module tb_top;
  import sgg_pkg::*;

  localparam int AXES             = 3;
  localparam int MAX_PER_PARTICLE = 26;
  localparam int unsigned CYCLE_LIMIT   = 2000000;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned PRINT_LIMIT   = 50;
  localparam longint ONE = 64'sd65536;          // 1.0 in Q16.16
  localparam logic [COORD_W-1:0] H_ONE = 32'h0001_0000;
  // indexes past the last register; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sgg_stream_if #(.T(particle_t)) particle_ch ();
  sgg_stream_if #(.T(ghost_t))    ghost_ch ();

  sph_ghost_particle_generator_unit #(
    .DIMS                    (AXES),
    .MAX_GHOSTS_PER_PARTICLE (MAX_PER_PARTICLE)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .particle  (particle_ch),
    .ghost     (ghost_ch)
  );

  always #10 clk = ~clk;

  // Shadow copy of the register file and the step's slot counter
  logic [63:0]        box_bounds [AXES];
  logic [MODES_W-1:0] face_modes = '0;
  logic [RF_W-1:0]    reach_q8   = REACH_RESET;
  logic [CNT_W-1:0]   slot_limit = CAPACITY_RESET;
  int unsigned        slots_used = 0;

  ghost_t      ghosts_due[$];
  int unsigned errors    = 0;
  int unsigned cycles    = 0;
  int unsigned hold_reqs = 0;
  bit          quiet     = 1'b0;

  initial begin
    for (int k = 0; k < AXES; k++) box_bounds[k] = '0;
  end

  // Timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report(input string msg);
    if (errors < PRINT_LIMIT) $display("%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Work out every ghost of one particle and queue the expected transactions
  function automatic void predict_ghosts(input particle_t item);
    longint      real_pos [3];
    longint      real_vel [3];
    longint      cpos [3];
    longint      cvel [3];
    longint      gpos [3];
    longint      gvel [3];
    longint      made_pos [MAX_PER_PARTICLE][3];
    longint      made_vel [MAX_PER_PARTICLE][3];
    int unsigned made_num [MAX_PER_PARTICLE];
    longint      reach, bmin, bmax, span, coord, bface;
    logic [1:0]  mode;
    int          kept, n;
    bit          lost, near_face;
    ghost_t      res;
    if (item.kind == KIND_BEGIN_STEP) begin
      slots_used = 0;
      return;
    end
    real_pos[0] = longint'($signed(item.pos_x));
    real_pos[1] = longint'($signed(item.pos_y));
    real_pos[2] = longint'($signed(item.pos_z));
    real_vel[0] = longint'($signed(item.vel_x));
    real_vel[1] = longint'($signed(item.vel_y));
    real_vel[2] = longint'($signed(item.vel_z));
    reach = longint'((64'(reach_q8) * 64'(item.smoothing_length)) >> 8);
    kept  = 0;
    lost  = 1'b0;
    for (int k = 0; k < AXES; k++) begin
      bmin = longint'($signed(box_bounds[k][31:0]));
      bmax = longint'($signed(box_bounds[k][63:32]));
      span = bmax - bmin;
      n    = kept;
      // the real particle first, then the ghosts made on earlier axes
      for (int c = 0; c <= n; c++) begin
        for (int j = 0; j < 3; j++) begin
          cpos[j] = (c == 0) ? real_pos[j] : made_pos[c-1][j];
          cvel[j] = (c == 0) ? real_vel[j] : made_vel[c-1][j];
        end
        coord = cpos[k];
        for (int side = 0; side < 2; side++) begin
          mode = face_modes[4*k + 2*side +: 2];
          if (mode == MODE_PERIODIC || mode == MODE_MIRROR) begin
            near_face = (side == 0) ? (coord < bmin + reach) : (coord > bmax - reach);
            if (near_face) begin
              gpos = cpos;
              gvel = cvel;
              if (mode == MODE_PERIODIC) begin
                gpos[k] = clamp32((side == 0) ? coord + span : coord - span);
              end else begin
                bface   = (side == 0) ? bmin : bmax;
                gpos[k] = clamp32(2 * bface - coord);
                gvel[k] = clamp32(-cvel[k]);
              end
              if (kept < MAX_PER_PARTICLE && slots_used < slot_limit) begin
                made_pos[kept] = gpos;
                made_vel[kept] = gvel;
                made_num[kept] = slots_used;
                kept++;
                slots_used++;
              end else begin
                lost = 1'b1;
              end
            end
          end
        end
      end
    end

    if (kept == 0) begin
      // nothing kept but something dropped: a single marker transaction
      if (lost) begin
        res = '0;
        res.source_index     = item.particle_index;
        res.ghost_number     = 16'(slots_used);
        res.last_of_particle = 1'b1;
        res.overflow         = 1'b1;
        ghosts_due.push_back(res);
      end
    end else begin
      for (int r = 0; r < kept; r++) begin
        res.source_index     = item.particle_index;
        res.ghost_number     = 16'(made_num[r]);
        res.ghost_x          = 32'(made_pos[r][0]);
        res.ghost_y          = 32'(made_pos[r][1]);
        res.ghost_z          = 32'(made_pos[r][2]);
        res.ghost_vx         = 32'(made_vel[r][0]);
        res.ghost_vy         = 32'(made_vel[r][1]);
        res.ghost_vz         = 32'(made_vel[r][2]);
        res.last_of_particle = (r == kept - 1);
        res.overflow         = lost;
        ghosts_due.push_back(res);
      end
    end
  endfunction

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want, input logic [15:0] src);
    if (got !== want)
      report($sformatf("ghost of particle %0d: %s is %h, expected %h", src, name, got, want));
  endtask

  task automatic check_ghost(input ghost_t got);
    ghost_t want;
    if (ghosts_due.size() == 0) begin
      report($sformatf("unexpected ghost transaction from particle %0d", got.source_index));
      return;
    end
    want = ghosts_due.pop_front();
    compare_field("source_index", got.source_index, want.source_index, want.source_index);
    compare_field("ghost_number", got.ghost_number, want.ghost_number, want.source_index);
    compare_field("ghost_x", got.ghost_x, want.ghost_x, want.source_index);
    compare_field("ghost_y", got.ghost_y, want.ghost_y, want.source_index);
    compare_field("ghost_z", got.ghost_z, want.ghost_z, want.source_index);
    compare_field("ghost_vx", got.ghost_vx, want.ghost_vx, want.source_index);
    compare_field("ghost_vy", got.ghost_vy, want.ghost_vy, want.source_index);
    compare_field("ghost_vz", got.ghost_vz, want.ghost_vz, want.source_index);
    compare_field("last_of_particle", got.last_of_particle, want.last_of_particle,
                  want.source_index);
    compare_field("overflow", got.overflow, want.overflow, want.source_index);
  endtask

  // Ghost receiver: checks each transaction and stalls in random bursts
  initial begin : ghost_sink
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned hold_seen;
    bit          take;
    stall_left = 0;
    hold_left  = 0;
    hold_seen  = 0;
    ghost_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && ghost_ch.valid && ghost_ch.ready) check_ghost(ghost_ch.payload);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        take = 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        take = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        take = 1'b0;
      end else begin
        take = 1'b1;
      end
      ghost_ch.ready <= take;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_BOX_X:    box_bounds[0] = value;
      REG_BOX_Y:    box_bounds[1] = value;
      REG_BOX_Z:    box_bounds[2] = value;
      REG_MODES:    face_modes = value[MODES_W-1:0];
      REG_REACH:    reach_q8 = value[RF_W-1:0];
      REG_CAPACITY: slot_limit = value[CNT_W-1:0];
      default: ;
    endcase
  endtask

  function automatic int unsigned pick_gap();
    if (quiet || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 19);
  endfunction

  // Offer one particle transaction and wait for it to be taken.
  // valid stays high on return; the caller either sends again or drains.
  task automatic send_item(input particle_t item);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      particle_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    particle_ch.valid   <= 1'b1;
    particle_ch.payload <= item;
    do @(posedge clk); while (!particle_ch.ready);
    predict_ghosts(item);
  endtask

  // Stop sending, let every expected ghost arrive, then let the block go idle
  task automatic drain_block();
    particle_ch.valid <= 1'b0;
    while (ghosts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] box_word(input longint lo, input longint hi);
    return {32'(hi), 32'(lo)};
  endfunction

  function automatic logic [MODES_W-1:0] modes_of(input logic [1:0] xl, xr, yl, yr, zl, zr);
    return {zr, zl, yr, yl, xr, xl};
  endfunction

  function automatic particle_t noise_item();
    particle_t item;
    item.kind             = 1'($urandom_range(0, 1));
    item.particle_index   = 16'($urandom);
    item.pos_x            = $urandom;
    item.pos_y            = $urandom;
    item.pos_z            = $urandom;
    item.vel_x            = $urandom;
    item.vel_y            = $urandom;
    item.vel_z            = $urandom;
    item.smoothing_length = $urandom;
    return item;
  endfunction

  function automatic particle_t begin_step_item();
    particle_t item;
    item = noise_item();
    item.kind = KIND_BEGIN_STEP;
    return item;
  endfunction

  function automatic particle_t particle_at(input logic [15:0] idx, input longint x, y, z,
                                            input logic [31:0] h);
    particle_t item;
    item = noise_item();
    item.kind             = KIND_PARTICLE;
    item.particle_index   = idx;
    item.pos_x            = 32'(x);
    item.pos_y            = 32'(y);
    item.pos_z            = 32'(z);
    item.smoothing_length = h;
    return item;
  endfunction

  // Coordinate placed mostly around the faces of the current box
  function automatic longint pick_coord(input int axis, input logic [31:0] h);
    longint lo, hi, reach, span;
    lo    = longint'($signed(box_bounds[axis][31:0]));
    hi    = longint'($signed(box_bounds[axis][63:32]));
    reach = longint'((64'(reach_q8) * 64'(h)) >> 8);
    span  = reach + 4;
    if (span > 64'sh3FFF_FFFF) span = 64'sh3FFF_FFFF;
    case ($urandom_range(0, 9))
      0, 1, 2: return lo + longint'($urandom_range(0, 32'(2 * span))) - span;
      3, 4, 5: return hi + longint'($urandom_range(0, 32'(2 * span))) - span;
      6:       return lo + reach + longint'($urandom_range(0, 2)) - 1;
      7:       return hi - reach + longint'($urandom_range(0, 2)) - 1;
      8:       return lo + (hi - lo) / 2 + longint'($urandom_range(0, 255));
      default: return longint'($signed($urandom));
    endcase
  endfunction

  function automatic particle_t random_particle();
    logic [31:0] h;
    case ($urandom_range(0, 19))
      0:       h = $urandom;
      1, 2, 3: h = $urandom_range(0, 32'h0010_0000);
      default: h = $urandom_range(0, 32'h0002_0000);
    endcase
    return particle_at(16'($urandom), pick_coord(0, h), pick_coord(1, h), pick_coord(2, h), h);
  endfunction

  function automatic longint corner_coord();
    return ($urandom_range(0, 1) != 0) ? 7 * ONE : -7 * ONE;
  endfunction

  task automatic random_setup();
    logic [63:0] word [AXES];
    for (int k = 0; k < AXES; k++) begin
      if ($urandom_range(0, 5) == 0) word[k] = {$urandom, $urandom};
      else word[k] = box_word(-longint'($urandom_range(1, 32'h0020_0000)),
                              longint'($urandom_range(1, 32'h0020_0000)));
    end
    write_reg(REG_BOX_X, word[0]);
    write_reg(REG_BOX_Y, word[1]);
    write_reg(REG_BOX_Z, word[2]);
    write_reg(REG_MODES, 64'($urandom_range(0, 4095)));
    case ($urandom_range(0, 9))
      0:       write_reg(REG_REACH, 64'd0);
      1:       write_reg(REG_REACH, 64'hFFFF);
      2:       write_reg(REG_REACH, 64'($urandom_range(0, 65535)));
      default: write_reg(REG_REACH, 64'($urandom_range(128, 1024)));
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: write_reg(REG_CAPACITY, 64'($urandom_range(0, 60)));
      3:       write_reg(REG_CAPACITY, 64'h1FFFF);
      4:       write_reg(REG_CAPACITY, 64'($urandom_range(0, 32'h1FFFF)));
      default: write_reg(REG_CAPACITY, 64'(CAPACITY_RESET));
    endcase
  endtask

  // Reset register values: every face open, so nothing comes out
  task automatic test_reset_state();
    send_item(particle_at(16'd1, 0, 0, 0, H_ONE));
    send_item(particle_at(16'd2, -ONE, ONE, 0, 32'hFFFF_FFFF));
    send_item(begin_step_item());
    drain_block();
  endtask

  // Periodic and mirror faces, corner ghosts, face edges and field extremes
  task automatic test_faces();
    particle_t item;
    write_reg(REG_BOX_X, box_word(-8 * ONE, 8 * ONE));
    write_reg(REG_BOX_Y, box_word(-8 * ONE, 8 * ONE));
    write_reg(REG_BOX_Z, box_word(-8 * ONE, 8 * ONE));
    write_reg(REG_MODES, modes_of(MODE_PERIODIC, MODE_PERIODIC, MODE_MIRROR, MODE_MIRROR,
                                  MODE_PERIODIC, MODE_MIRROR));
    write_reg(REG_REACH, 64'(REACH_RESET));
    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, {$urandom, $urandom});
    send_item(particle_at(16'd10, 0, 0, 0, H_ONE));
    send_item(particle_at(16'd11, -7 * ONE, -7 * ONE, -7 * ONE, H_ONE));
    send_item(particle_at(16'd12, 7 * ONE, 7 * ONE, 7 * ONE, H_ONE));
    // every face near: the full set of corner ghosts
    send_item(particle_at(16'd13, ONE, -ONE, 0, 8 * H_ONE));
    send_item(particle_at(16'hFFFF, 0, 0, 0, 32'hFFFF_FFFF));
    // sitting exactly on a face with zero reach is not near; one step past it is
    send_item(particle_at(16'd14, -8 * ONE, 0, 0, 32'd0));
    send_item(particle_at(16'd15, -8 * ONE - 1, 0, 0, 32'd0));
    send_item(particle_at(16'd16, 8 * ONE, 8 * ONE + 1, 0, 32'd0));
    item = particle_at(16'd17, -64'sd2147483648, 64'sd2147483647, -64'sd2147483648, 32'd0);
    item.vel_x = 32'h8000_0000;
    item.vel_y = 32'h8000_0000;
    item.vel_z = 32'h7FFF_FFFF;
    send_item(item);
    send_item(begin_step_item());
    drain_block();
    // open and unused codes make no ghosts
    write_reg(REG_MODES, modes_of(MODE_NONE, MODE_OPEN, MODE_OPEN, MODE_NONE,
                                  MODE_NONE, MODE_OPEN));
    send_item(particle_at(16'd18, -7 * ONE, 7 * ONE, -7 * ONE, 4 * H_ONE));
    drain_block();
  endtask

  // Slot capacity: partial drops, a particle losing everything, zero capacity
  task automatic test_capacity();
    write_reg(REG_MODES, modes_of(MODE_PERIODIC, MODE_PERIODIC, MODE_MIRROR, MODE_MIRROR,
                                  MODE_PERIODIC, MODE_MIRROR));
    write_reg(REG_CAPACITY, 64'd3);
    send_item(begin_step_item());
    send_item(particle_at(16'd20, -7 * ONE, -7 * ONE, -7 * ONE, H_ONE));
    send_item(particle_at(16'd21, 7 * ONE, 0, 0, H_ONE));
    drain_block();
    write_reg(REG_CAPACITY, 64'd0);
    send_item(begin_step_item());
    send_item(particle_at(16'd22, 0, 7 * ONE, 0, H_ONE));
    drain_block();
    write_reg(REG_CAPACITY, 64'h1FFFF);
    send_item(begin_step_item());
    drain_block();
  endtask

  // Full-range box for saturation, inverted box on y
  task automatic test_saturation();
    particle_t item;
    write_reg(REG_BOX_X, {32'h7FFF_FFFF, 32'h8000_0000});
    write_reg(REG_BOX_Y, box_word(4 * ONE, -4 * ONE));
    write_reg(REG_BOX_Z, box_word(-8 * ONE, 8 * ONE));
    write_reg(REG_MODES, modes_of(MODE_MIRROR, MODE_PERIODIC, MODE_PERIODIC, MODE_PERIODIC,
                                  MODE_PERIODIC, MODE_MIRROR));
    item = particle_at(16'd30, -64'sd2147483648 + 5 * ONE, 0, 0, H_ONE);
    item.vel_x = 32'h8000_0000;
    send_item(item);
    send_item(particle_at(16'd31, 64'sd2147483647 - ONE, 2 * ONE, 7 * ONE, H_ONE));
    drain_block();
  endtask

  // Random registers, phase by phase, with random particles and noise
  task automatic test_random_phases();
    for (int p = 0; p < 20; p++) begin
      drain_block();
      random_setup();
      if ($urandom_range(0, 1) != 0) send_item(begin_step_item());
      for (int i = 0; i < 20; i++) begin
        case ($urandom_range(0, 19))
          0:       send_item(begin_step_item());
          1:       send_item(noise_item());
          default: send_item(random_particle());
        endcase
      end
    end
    drain_block();
  endtask

  // Long receiver hold-off while particles keep coming: input must stall
  task automatic test_backpressure();
    write_reg(REG_BOX_X, box_word(-8 * ONE, 8 * ONE));
    write_reg(REG_BOX_Y, box_word(-8 * ONE, 8 * ONE));
    write_reg(REG_BOX_Z, box_word(-8 * ONE, 8 * ONE));
    write_reg(REG_MODES, modes_of(MODE_MIRROR, MODE_MIRROR, MODE_PERIODIC, MODE_PERIODIC,
                                  MODE_MIRROR, MODE_PERIODIC));
    write_reg(REG_CAPACITY, 64'(CAPACITY_RESET));
    quiet = 1'b1;
    hold_reqs++;
    send_item(begin_step_item());
    for (int i = 0; i < 10; i++)
      send_item(particle_at(16'(40 + i), corner_coord(), corner_coord(), corner_coord(), H_ONE));
    quiet = 1'b0;
    drain_block();
  endtask

  // Closing stretch at full rate on both sides
  task automatic test_quiet_stream();
    random_setup();
    quiet = 1'b1;
    for (int i = 0; i < 50; i++) send_item(random_particle());
  endtask

  initial begin
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= '0;
    cfg_data            <= '0;
    particle_ch.valid   <= 1'b0;
    particle_ch.payload <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_faces();
    test_capacity();
    test_saturation();
    test_random_phases();
    test_backpressure();
    test_quiet_stream();
    drain_block();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
